// ===== sv/swta_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swta_pkg : shared types and constants
// Widths, item kinds and register indexes of the winner-take-all layer.
// ---------------------------------------------------------------------------
package swta_pkg;
    localparam int NEURONS   = 10;
    localparam int INPUTS    = 1024;
    localparam int MAX_STEPS = 256;
    localparam int NW        = $clog2(NEURONS);
    localparam int CW        = $clog2(NEURONS + 1);
    localparam int PW        = 10;
    localparam int AW        = $clog2(INPUTS);
    localparam int SW        = 8;
    localparam int CFG_W     = 40;
    localparam int CFG_IW    = 3;

    localparam logic [1:0] K_LOAD  = 2'd0;
    localparam logic [1:0] K_SPIKE = 2'd1;
    localparam logic [1:0] K_STEP  = 2'd2;
    localparam logic [1:0] K_IMAGE = 2'd3;

    localparam logic [CFG_IW-1:0] R_REST  = 3'd0;
    localparam logic [CFG_IW-1:0] R_LEAK  = 3'd1;
    localparam logic [CFG_IW-1:0] R_RESET = 3'd2;
    localparam logic [CFG_IW-1:0] R_INHIB = 3'd3;
    localparam logic [CFG_IW-1:0] R_THR   = 3'd4;
    localparam logic [CFG_IW-1:0] R_REFR  = 3'd5;
    localparam logic [CFG_IW-1:0] R_LABEL = 3'd6;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;
    localparam logic [8:0] COUNT_MAX = 9'd511;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         neuron_index;
        logic [PW-1:0]      presyn_index;
        logic signed [15:0] weight_value;
    } t_in;

    typedef struct packed {
        logic [7:0] step_number;
        logic [3:0] winner;
        logic       fired;
        logic [3:0] best_neuron;
        logic [3:0] class_label;
    } t_out;

    typedef struct packed {
        logic signed [31:0] rest;
        logic [30:0]        leak;
        logic signed [31:0] reset_p;
        logic signed [31:0] inhib;
        logic signed [31:0] thr0;
        logic [7:0]         refr;
    } t_cfg;

    // control from the sequencer to every cell
    typedef struct packed {
        logic       clear;
        logic       acc_en;
        logic       integ;
        logic       decide;
        logic       fired;
        logic [NW-1:0] win;
        logic       wrap;
        logic [SW-1:0] step;
    } t_ctl;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [32:0] b);
        logic signed [33:0] s;
        s = 34'(a) + 34'(b);
        if (s > 34'(Q_MAX)) return Q_MAX;
        if (s < 34'(Q_MIN)) return Q_MIN;
        return s[31:0];
    endfunction
endpackage

// ===== sv/swta_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swta_if : valid/ready channel
// Carries one item of the given payload type.
// ---------------------------------------------------------------------------
interface swta_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/swta_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swta_cell : one neuron
// Holds its weight column, accumulator, potential, threshold and count;
// passes the running maximum of potential and count on to the next cell.
// ---------------------------------------------------------------------------
module swta_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [swta_pkg::NW-1:0]         i_id,
    input  swta_pkg::t_cfg                  i_cfg,
    input  swta_pkg::t_ctl                  i_ctl,
    input  logic                            i_we,
    input  logic [swta_pkg::AW-1:0]         i_addr,
    input  logic signed [15:0]              i_wdata,
    input  logic signed [31:0]              i_max_p,
    input  logic [swta_pkg::NW-1:0]         i_max_pi,
    input  logic [8:0]                      i_max_c,
    input  logic [swta_pkg::NW-1:0]         i_max_ci,
    output logic signed [31:0]              o_max_p,
    output logic [swta_pkg::NW-1:0]         o_max_pi,
    output logic [8:0]                      o_max_c,
    output logic [swta_pkg::NW-1:0]         o_max_ci,
    output logic signed [31:0]              o_thr
);
    import swta_pkg::*;

    logic signed [15:0] mem [INPUTS];
    logic signed [15:0] r_w;
    logic signed [31:0] r_acc, r_pot, r_thr;
    logic [8:0]         r_cnt;
    logic [SW:0]        r_until;
    logic               r_idle;
    logic signed [31:0] n_pot, sum;
    logic               act;
    logic signed [31:0] r_mp;
    logic [NW-1:0]      r_mpi;
    logic [8:0]         r_mc;
    logic [NW-1:0]      r_mci;

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_addr] <= i_wdata;
        r_w <= mem[i_addr];
    end

    // refractory while rest_until (-1 = idle flag) not below step
    assign act = r_idle || (r_until < {1'b0, i_ctl.step});

    always_comb begin
        sum   = sat_add(r_pot, 33'(r_acc));
        n_pot = (sum > i_cfg.rest) ? sat_add(sum, -33'(signed'({1'b0, i_cfg.leak}))) : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_acc   <= '0;
            r_pot   <= i_cfg.rest;
            r_thr   <= i_cfg.thr0;
            r_cnt   <= '0;
            r_idle  <= 1'b1;
            r_until <= '0;
        end else begin
            if (i_ctl.acc_en) r_acc <= sat_add(r_acc, 33'(r_w));
            if (i_ctl.integ) begin
                if (act) r_pot <= n_pot;
                r_acc <= '0;
            end
            if (i_ctl.decide) begin
                if (i_ctl.fired) begin
                    r_until <= {1'b0, i_ctl.step} + (SW+1)'(i_cfg.refr);
                    if (i_ctl.win == i_id) begin
                        r_pot <= i_cfg.reset_p;
                        r_thr <= sat_add(r_thr, -33'sd256);
                        if (r_cnt != COUNT_MAX) r_cnt <= r_cnt + 9'd1;
                    end else begin
                        r_pot <= i_cfg.inhib;
                        if (r_pot > r_thr && r_cnt != COUNT_MAX) r_cnt <= r_cnt + 9'd1;
                    end
                end
                if (i_ctl.fired || i_ctl.wrap) r_idle <= i_ctl.wrap;
            end
        end
    end

    // running maxima, one cell further along the row each cycle
    always_ff @(posedge i_clk) begin
        if (r_pot > i_max_p) begin
            r_mp <= r_pot; r_mpi <= i_id;
        end else begin
            r_mp <= i_max_p; r_mpi <= i_max_pi;
        end
        if (r_cnt > i_max_c) begin
            r_mc <= r_cnt; r_mci <= i_id;
        end else begin
            r_mc <= i_max_c; r_mci <= i_max_ci;
        end
    end

    assign o_max_p  = r_mp;
    assign o_max_pi = r_mpi;
    assign o_max_c  = r_mc;
    assign o_max_ci = r_mci;
    assign o_thr    = r_thr;
endmodule

// ===== sv/spiking_winner_take_all_layer_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spiking_winner_take_all_layer_top : WTA spiking output layer
// A row of neuron cells with a small sequencer for end of step.
// ---------------------------------------------------------------------------
// Weight loads and new-image marks are handled in the idle state; a spike
// reads the weight from each cell's column memory, then accumulates, and no
// new item is accepted until it is done. An end-of-step mark is accepted,
// then integrated; a scan of potentials along the registered cell row ends in
// fire/inhibit, then a scan of counts follows. Its item enters the output
// register at the end of the count scan and need not be taken before the
// next input item is accepted, unless that item is another end-of-step mark.
module spiking_winner_take_all_layer_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    swta_if.sink                         s_in,
    swta_if.source                       m_out,
    input  logic                         i_cfg_we,
    input  logic [swta_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [swta_pkg::CFG_W-1:0]   i_cfg_data
);
    import swta_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_ACC = 3'd1, S_INT = 3'd2,
                           S_WIN = 3'd3, S_CNT = 3'd4, S_OUT = 3'd5;

    t_cfg         r_cfg;
    logic [39:0]  r_label;
    logic [2:0]   r_st;
    logic [SW-1:0] r_step;
    t_in          r_item;
    logic [NW-1:0] r_win;
    logic         r_fired;
    logic         r_ov;
    t_out         r_out;
    t_ctl         ctl;
    logic         acc_ok;
    logic [CW-1:0] r_scan;
    logic         scan_done;

    logic signed [31:0] mp [NEURONS+1];
    logic [NW-1:0]      mpi [NEURONS+1];
    logic [8:0]         mc [NEURONS+1];
    logic [NW-1:0]      mci [NEURONS+1];
    logic signed [31:0] thr_w;
    logic               we_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= '{rest: '0, leak: '0, reset_p: '0, inhib: '0, thr0: '0, refr: 8'd15};
            r_label <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                R_REST:  r_cfg.rest    <= i_cfg_data[31:0];
                R_LEAK:  r_cfg.leak    <= i_cfg_data[30:0];
                R_RESET: r_cfg.reset_p <= i_cfg_data[31:0];
                R_INHIB: r_cfg.inhib   <= i_cfg_data[31:0];
                R_THR:   r_cfg.thr0    <= i_cfg_data[31:0];
                R_REFR:  r_cfg.refr    <= i_cfg_data[7:0];
                R_LABEL: r_label       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wire take = s_in.valid && s_in.ready;
    assign s_in.ready = (r_st == S_IDLE) && !(r_ov && s_in.data.kind == K_STEP);
    assign we_any = take && s_in.data.kind == K_LOAD && 32'(s_in.data.neuron_index) < NEURONS
                    && 32'(s_in.data.presyn_index) < INPUTS;
    assign acc_ok = 32'(r_item.presyn_index) < INPUTS;
    assign scan_done = (32'(r_scan) == NEURONS);

    always_comb begin
        ctl        = '0;
        ctl.clear  = take && s_in.data.kind == K_IMAGE;
        ctl.acc_en = (r_st == S_ACC) && acc_ok;
        ctl.integ  = (r_st == S_INT);
        ctl.decide = (r_st == S_WIN) && scan_done;
        ctl.fired  = ctl.decide && (mp[NEURONS] > thr_w);
        ctl.win    = mpi[NEURONS];
        ctl.wrap   = ctl.decide && (32'(r_step) == MAX_STEPS-1);
        ctl.step   = r_step;
    end

    assign mp[0] = Q_MIN; assign mpi[0] = '0;
    assign mc[0] = '0;    assign mci[0] = '0;

    logic signed [31:0] thr_v [NEURONS];
    for (genvar g = 0; g < NEURONS; g++) begin : g_cell
        swta_cell u_cell (
            .i_clk, .i_rst_n, .i_id(NW'(g)), .i_cfg(r_cfg), .i_ctl(ctl),
            .i_we(we_any && s_in.data.neuron_index == 4'(g)),
            .i_addr(take ? AW'(s_in.data.presyn_index) : AW'(r_item.presyn_index)),
            .i_wdata(s_in.data.weight_value),
            .i_max_p(mp[g]), .i_max_pi(mpi[g]),
            .i_max_c(mc[g]), .i_max_ci(mci[g]),
            .o_max_p(mp[g+1]), .o_max_pi(mpi[g+1]),
            .o_max_c(mc[g+1]), .o_max_ci(mci[g+1]),
            .o_thr(thr_v[g])
        );
    end
    assign thr_w = thr_v[mpi[NEURONS]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_step <= '0; r_ov <= 1'b0; r_scan <= '0;
        end else begin
            if (m_out.valid && m_out.ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (take) begin
                    r_item <= s_in.data;
                    case (s_in.data.kind)
                        K_SPIKE: r_st <= S_ACC;
                        K_STEP:  r_st <= S_INT;
                        K_IMAGE: r_step <= '0;
                        default: ;
                    endcase
                end
                S_ACC: r_st <= S_IDLE;
                S_INT: begin
                    r_st <= S_WIN; r_scan <= '0;
                end
                S_WIN: begin
                    if (scan_done) begin
                        r_win <= mpi[NEURONS]; r_fired <= ctl.fired; r_st <= S_CNT;
                        r_scan <= '0;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_CNT: begin
                    if (scan_done) begin
                        r_out.step_number <= r_step;
                        r_out.winner      <= 4'(r_win);
                        r_out.fired       <= r_fired;
                        r_out.best_neuron <= 4'(mci[NEURONS]);
                        r_out.class_label <= r_label[4*mci[NEURONS] +: 4];
                        r_ov   <= 1'b1;
                        r_step <= (32'(r_step) == MAX_STEPS-1) ? '0 : r_step + 1'b1;
                        r_st   <= S_IDLE;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign m_out.valid = r_ov;
    assign m_out.data  = r_out;
endmodule

// ===== sv/swta_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swta_checker : port-level checks
// Watches the item channels of the top level.
// ---------------------------------------------------------------------------
module swta_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  in_kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  out_winner,
    input logic [3:0]  out_best
);
    import swta_pkg::*;

    a_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> 32'(out_winner) < NEURONS && 32'(out_best) < NEURONS)
        else $error("index out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_winner))
        else $error("item dropped");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_kind == K_STEP |=> !in_ready)
        else $error("no step work");
endmodule

bind spiking_winner_take_all_layer_top swta_checker u_chk (
    .i_clk, .i_rst_n, .in_valid(s_in.valid), .in_ready(s_in.ready),
    .in_kind(s_in.data.kind), .out_valid(m_out.valid), .out_ready(m_out.ready),
    .out_winner(m_out.data.winner), .out_best(m_out.data.best_neuron)
);
